// ----- hdl/llf_pkg.sv -----
// Shared types and constants for the link-loss failsafe block.
`timescale 1ns / 1ps

package llf_pkg;

    localparam int PHASE_W      = 10;
    localparam int LOSS_W       = 16;
    localparam int SLOT_W       = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [PHASE_W-1:0] PHASE_LAST   = PHASE_W'(999);
    localparam logic [PHASE_W-1:0] BLINK_ON_A   = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] BLINK_ON_B   = PHASE_W'(130);
    localparam logic [PHASE_W-1:0] BLINK_OFF_A  = PHASE_W'(30);
    localparam logic [PHASE_W-1:0] BLINK_OFF_B  = PHASE_W'(160);
    localparam logic [PHASE_W-1:0] LOST_ON_MAX  = PHASE_W'(500);

    localparam logic [LOSS_W-1:0]  LOSS_LIMIT_RST = LOSS_W'(500);
    localparam logic [SLOT_W-1:0]  SLOT_DIV_RST   = SLOT_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOSS_LIMIT   = 1'b0,
        CFG_SLOT_DIVIDER = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic fresh_packet;
    } t_in_item;

    typedef struct packed {
        logic led_on;
        logic link_up;
        logic motors_allowed;
        logic slot_strobe;
    } t_out_item;

endpackage

// ----- hdl/llf_in_if.sv -----
// Tick input channel: valid/ready with the tick item.
`timescale 1ns / 1ps

interface llf_in_if;
    logic               valid;
    logic               ready;
    llf_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/llf_out_if.sv -----
// Result channel: valid/ready with the status item.
`timescale 1ns / 1ps

interface llf_out_if;
    logic                valid;
    logic                ready;
    llf_pkg::t_out_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/llf_in_stage.sv -----
// Input register stage holding one accepted tick item.
`timescale 1ns / 1ps

module llf_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  llf_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output llf_pkg::t_in_item o_item
);
    import llf_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // free slot, or the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ----- hdl/llf_update.sv -----
// Failsafe state, config registers and the per-tick next-state logic.
`timescale 1ns / 1ps

module llf_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  llf_pkg::t_cfg_wr   i_cfg,
    input  logic               i_fire,
    input  llf_pkg::t_in_item  i_item,
    output llf_pkg::t_out_item o_result
);
    import llf_pkg::*;

    logic [LOSS_W-1:0]  r_loss_limit;
    logic [SLOT_W-1:0]  r_slot_div;
    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [LOSS_W-1:0]  r_loss,   n_loss;
    logic               r_link,   n_link;
    logic               r_motor,  n_motor;
    logic               r_led,    n_led;
    logic [SLOT_W-1:0]  r_slot,   n_slot;
    logic               n_strobe;
    logic [LOSS_W-1:0]  loss_inc;
    logic [SLOT_W-1:0]  slot_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_limit <= LOSS_LIMIT_RST;
            r_slot_div   <= SLOT_DIV_RST;
        end else if (i_cfg.we) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_LOSS_LIMIT:   r_loss_limit <= i_cfg.data[LOSS_W-1:0];
                CFG_SLOT_DIVIDER: r_slot_div   <= i_cfg.data[SLOT_W-1:0];
                default:          r_loss_limit <= r_loss_limit;
            endcase
        end
    end

    always_comb begin
        n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + PHASE_W'(1);

        // LED follows the link state held before this tick's update
        n_led = r_led;
        if (r_link) begin
            if (n_phase == BLINK_ON_A || n_phase == BLINK_ON_B) begin
                n_led = 1'b1;
            end
            if (n_phase == BLINK_OFF_A || n_phase == BLINK_OFF_B) begin
                n_led = 1'b0;
            end
        end else begin
            n_led = (n_phase <= LOST_ON_MAX);
        end

        loss_inc = r_loss + LOSS_W'(1);
        n_loss   = loss_inc;
        n_link   = r_link;
        n_motor  = r_motor;
        if (i_item.fresh_packet) begin
            n_loss  = '0;
            n_link  = 1'b1;
            n_motor = 1'b1;
        end else if (loss_inc >= r_loss_limit) begin
            n_loss  = '0;
            n_link  = 1'b0;
            n_motor = 1'b0;
        end

        slot_inc = r_slot + SLOT_W'(1);
        n_slot   = slot_inc;
        n_strobe = 1'b0;
        if (slot_inc >= r_slot_div) begin
            n_slot   = '0;
            n_strobe = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_loss  <= '0;
            r_link  <= 1'b0;
            r_motor <= 1'b0;
            r_led   <= 1'b0;
            r_slot  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_loss  <= n_loss;
            r_link  <= n_link;
            r_motor <= n_motor;
            r_led   <= n_led;
            r_slot  <= n_slot;
        end
    end

    assign o_result.led_on         = n_led;
    assign o_result.link_up        = n_link;
    assign o_result.motors_allowed = n_motor;
    assign o_result.slot_strobe    = n_strobe;
endmodule

// ----- hdl/llf_out_stage.sv -----
// Result register stage facing the output channel.
`timescale 1ns / 1ps

module llf_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  llf_pkg::t_out_item i_item,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output llf_pkg::t_out_item o_item
);
    import llf_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ----- hdl/link_loss_failsafe_with_status_led.sv -----
// Top level of the link-loss failsafe watchdog with status LED.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    fresh_packet
//  o_out     out  valid/ready    led_on, link_up, motors_allowed, slot_strobe
//  i_cfg_*   in   write enable   index 0 loss_limit, 1 slot_divider
//
// One tick item per clock while the output is not stalled; each item is held
// in the input register, is evaluated against the failsafe state, and lands
// in the result register, from which it is offered on the output channel.
// A stalled output holds the result register and then the input register;
// the block keeps taking items as long as either register can move.
// Synchronous active-low reset clears all state; config returns to
// loss_limit 500 and slot_divider 5.
`timescale 1ns / 1ps

module link_loss_failsafe_with_status_led (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [llf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [llf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    llf_in_if.sink                           i_in,
    llf_out_if.source                        o_out
);
    import llf_pkg::*;

    t_cfg_wr   cfg;
    logic      stage_valid;
    t_in_item  stage_item;
    logic      out_can_load;
    logic      advance;
    t_out_item result;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // The held tick moves into the result register, and the state is
    // updated, in the same cycle; nothing else ever touches the state.
    assign advance = stage_valid && out_can_load;

    llf_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_item    (i_in.payload),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    llf_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (stage_item),
        .o_result (result)
    );

    llf_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stage_valid),
        .i_item     (result),
        .o_can_load (out_can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_item     (o_out.payload)
    );
endmodule
